/* sv/assert_macros.svh */
// Assertion macros shared by the encoder RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clk edge outside reset
`define ABRE_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Check that the antecedent implies the consequent in the same cycle
`define ABRE_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

/* sv/abre_pkg.sv */
// Types, constants and the adaptation rate table of the range encoder
`default_nettype none

package abre_pkg;

    localparam int REQ_W        = 12;
    localparam int REDUCE_STEPS = 9;
    localparam int RATE_W       = 6;

    localparam logic [31:0] CTX_INIT     = 32'h8000_0000;
    localparam logic [31:0] PROB_ONE     = 32'h0080_0000;
    localparam logic [31:0] DELTA_MASK   = 32'hFFFF_FF80;
    localparam logic [6:0]  COUNT_MAX    = 7'd127;
    localparam logic [8:0]  LOW_TOP_HOLD = 9'h0FF;
    localparam logic [7:0]  FILL_CARRY   = 8'h00;
    localparam logic [7:0]  FILL_NONE    = 8'hFF;
    localparam logic [3:0]  BYPASS_MAX   = 4'd8;
    localparam logic [3:0]  FLUSH_STEPS  = 4'd5;

    typedef enum logic [1:0] {
        FUNC_MODEL     = 2'd0,
        FUNC_BYPASS    = 2'd1,
        FUNC_FLUSH     = 2'd2,
        FUNC_CTX_RESET = 2'd3
    } func_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MCALC,
        ST_MUPD,
        ST_BYPASS,
        ST_RENORM,
        ST_FLUSH,
        ST_DONE
    } state_t;

    // floor(4096 / (n + 128))
    function automatic logic [RATE_W-1:0] rate_lookup(input logic [6:0] n);
        logic [RATE_W-1:0] rate;
        unique case (n) inside
            7'd0:               rate = 6'd32;
            [7'd1:7'd4]:        rate = 6'd31;
            [7'd5:7'd8]:        rate = 6'd30;
            [7'd9:7'd13]:       rate = 6'd29;
            [7'd14:7'd18]:      rate = 6'd28;
            [7'd19:7'd23]:      rate = 6'd27;
            [7'd24:7'd29]:      rate = 6'd26;
            [7'd30:7'd35]:      rate = 6'd25;
            [7'd36:7'd42]:      rate = 6'd24;
            [7'd43:7'd50]:      rate = 6'd23;
            [7'd51:7'd58]:      rate = 6'd22;
            [7'd59:7'd67]:      rate = 6'd21;
            [7'd68:7'd76]:      rate = 6'd20;
            [7'd77:7'd87]:      rate = 6'd19;
            [7'd88:7'd99]:      rate = 6'd18;
            [7'd100:7'd112]:    rate = 6'd17;
            default:            rate = 6'd16;
        endcase
        return rate;
    endfunction

endpackage

`default_nettype wire

/* sv/abre_ctx_ram.sv */
// Context word memory, one port, registered read
`default_nettype none

module abre_ctx_ram #(
    parameter int DEPTH  = 4096,
    parameter int ADDR_W = 12
) (
    input  logic              clk,
    input  logic [ADDR_W-1:0] addr,
    input  logic              we,
    input  logic [31:0]       wdata,
    output logic [31:0]       rdata
);

    logic [31:0] mem [DEPTH];
    logic [31:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

/* sv/abre_model.sv */
// Probability model: subrange product and context word update, registered
`default_nettype none

module abre_model import abre_pkg::*; (
    input  logic        clk,
    input  logic [31:0] word,
    input  logic        bit_val,
    input  logic [31:0] range_width,
    output logic [31:0] part,
    output logic [31:0] word_upd
);

    logic [22:0]       prob;
    logic [11:0]       scale;
    logic [6:0]        adapt;
    logic [RATE_W-1:0] rate;
    logic [31:0]       diff;
    logic [31:0]       delta;
    logic [31:0]       part_next;
    logic [31:0]       word_next;
    logic [31:0]       part_reg;
    logic [31:0]       word_reg;

    always_comb
    begin
        prob      = word[31:9];
        scale     = (prob[22:11] == 12'd0) ? 12'd1 : prob[22:11];
        adapt     = word[6:0];
        rate      = rate_lookup(adapt);
        part_next = {12'd0, range_width[31:12]} * {20'd0, scale};
        diff      = (bit_val ? PROB_ONE : 32'd0) - {9'd0, prob};
        delta     = diff * 32'(rate);
        word_next = word + (delta & DELTA_MASK)
                  + {31'd0, (adapt != COUNT_MAX)};
    end

    always_ff @(posedge clk)
    begin
        part_reg <= part_next;
        word_reg <= word_next;
    end

    assign part     = part_reg;
    assign word_upd = word_reg;

endmodule

`default_nettype wire

/* sv/adaptive_binary_range_encoder.sv */
// Adaptive binary range encoder top level: control, coder state, result staging
//
//   channel | direction | fields                                   | handshake
//   in      | sink      | func, context_req, bits, bit_count       | in_valid / in_ready
//   out     | source    | lead_byte, fill_byte, fill_count, last   | out_valid / out_ready
//
// Modeled bit: context memory read, model update, write back, then byte steps.
// Bypass: halving step, then renormalization, per bit. Flush: halving, then byte steps.
// Context reset: one word written. After reset all words are cleared, in_ready low.
// A releasing byte step stalls while a result is staged and the output register is full.
`default_nettype none
`include "assert_macros.svh"

module adaptive_binary_range_encoder import abre_pkg::*; #(
    parameter int CONTEXTS = 4096
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  func,
    input  logic [11:0] context_req,
    input  logic [7:0]  bits,
    input  logic [3:0]  bit_count,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  lead_byte,
    output logic [7:0]  fill_byte,
    output logic [31:0] fill_count,
    output logic        last
);

    localparam int IDX_W = $clog2(CONTEXTS);

    state_t state_reg, state_next;

    logic [3:0]       cnt_reg, cnt_next;
    logic             flush_reg, flush_next;
    logic [7:0]       bits_reg, bits_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [IDX_W-1:0] clr_reg, clr_next;
    logic [31:0]      range_reg, range_next;
    logic [32:0]      low_reg, low_next;
    logic [7:0]       held_reg, held_next;
    logic [31:0]      pend_reg, pend_next;
    logic             stg_valid_reg, stg_valid_next;
    logic [7:0]       stg_lead_reg, stg_lead_next;
    logic [7:0]       stg_fill_reg, stg_fill_next;
    logic [31:0]      stg_count_reg, stg_count_next;
    logic             out_valid_reg, out_valid_next;
    logic [7:0]       lead_reg, lead_next;
    logic [7:0]       fill_reg, fill_next;
    logic [31:0]      count_reg, count_next;
    logic             last_reg, last_next;

    logic [REQ_W-1:0] idx_rem;
    logic [IDX_W-1:0] idx_in;
    logic [3:0]       byp_count;
    logic             byp_bit;
    logic [31:0]      range_half;

    logic             ram_we;
    logic [IDX_W-1:0] ram_addr;
    logic [31:0]      ram_wdata;
    logic [31:0]      ram_rdata;
    logic [31:0]      model_part;
    logic [31:0]      model_word;

    logic             need_renorm;
    logic             step_release;
    logic [7:0]       step_lead;
    logic [7:0]       step_fill;
    logic [32:0]      step_low;
    logic             step_req;
    logic             finish_req;
    logic             out_free;
    logic             stall;
    logic             do_step;
    logic             do_finish;
    logic             push_out;

    // reduce the request modulo CONTEXTS by conditional subtraction
    always_comb
    begin
        idx_rem = context_req;
        for (int k = REDUCE_STEPS - 1; k >= 0; k--)
        begin
            if ((CONTEXTS << k) < (1 << REQ_W))
            begin
                if (idx_rem >= REQ_W'(CONTEXTS << k))
                begin
                    idx_rem = idx_rem - REQ_W'(CONTEXTS << k);
                end
            end
        end
        idx_in = IDX_W'(idx_rem);
    end

    always_comb
    begin
        byp_count    = (bit_count > BYPASS_MAX) ? BYPASS_MAX : bit_count;
        byp_bit      = !flush_reg && bits_reg[3'(cnt_reg - 4'd1)];
        range_half   = range_reg >> 1;
        need_renorm  = (range_reg[31:24] == 8'h00);
        step_release = (low_reg[32:24] != LOW_TOP_HOLD);
        step_lead    = held_reg + {7'd0, low_reg[32]};
        step_fill    = low_reg[32] ? FILL_CARRY : FILL_NONE;
        step_low     = {1'b0, low_reg[23:0], 8'h00};
    end

    abre_ctx_ram #(
        .DEPTH  (CONTEXTS),
        .ADDR_W (IDX_W)
    ) u_ctx_ram (
        .clk   (clk),
        .addr  (ram_addr),
        .we    (ram_we),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    abre_model u_model (
        .clk         (clk),
        .word        (ram_rdata),
        .bit_val     (bits_reg[0]),
        .range_width (range_reg),
        .part        (model_part),
        .word_upd    (model_word)
    );

    // control outputs
    always_comb
    begin
        in_ready   = 1'b0;
        ram_we     = 1'b0;
        ram_addr   = idx_reg;
        ram_wdata  = CTX_INIT;
        step_req   = 1'b0;
        finish_req = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                ram_we   = 1'b1;
                ram_addr = clr_reg;
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                ram_addr = idx_in;
                ram_we   = in_valid && (func_t'(func) == FUNC_CTX_RESET);
            end
            ST_MUPD:
            begin
                ram_we    = 1'b1;
                ram_wdata = model_word;
            end
            ST_RENORM:
            begin
                step_req   = need_renorm;
                finish_req = !need_renorm && (cnt_reg == 4'd0) && !flush_reg;
            end
            ST_FLUSH:
            begin
                step_req = 1'b1;
            end
            ST_DONE:
            begin
                finish_req = 1'b1;
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
        out_free  = !out_valid_reg || out_ready;
        stall     = ((step_req && step_release) || finish_req)
                  && stg_valid_reg && !out_free;
        do_step   = step_req && !stall;
        do_finish = finish_req && !stall;
        push_out  = stg_valid_reg && ((do_step && step_release) || do_finish);
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_reg == IDX_W'(CONTEXTS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    unique case (func_t'(func))
                        FUNC_MODEL:     state_next = ST_MCALC;
                        FUNC_BYPASS:    state_next = (byp_count != 4'd0) ? ST_BYPASS : ST_IDLE;
                        FUNC_FLUSH:     state_next = ST_BYPASS;
                        FUNC_CTX_RESET: state_next = ST_IDLE;
                    endcase
                end
            end
            ST_MCALC:  state_next = ST_MUPD;
            ST_MUPD:   state_next = ST_RENORM;
            ST_BYPASS: state_next = ST_RENORM;
            ST_RENORM:
            begin
                if (!need_renorm)
                begin
                    if (cnt_reg != 4'd0)
                    begin
                        state_next = ST_BYPASS;
                    end
                    else if (flush_reg)
                    begin
                        state_next = ST_FLUSH;
                    end
                    else if (do_finish)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_FLUSH:
            begin
                if (do_step && (cnt_reg == 4'd1))
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (do_finish)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath next values
    always_comb
    begin
        cnt_next       = cnt_reg;
        flush_next     = flush_reg;
        bits_next      = bits_reg;
        idx_next       = idx_reg;
        clr_next       = clr_reg;
        range_next     = range_reg;
        low_next       = low_reg;
        held_next      = held_reg;
        pend_next      = pend_reg;
        stg_valid_next = stg_valid_reg;
        stg_lead_next  = stg_lead_reg;
        stg_fill_next  = stg_fill_reg;
        stg_count_next = stg_count_reg;
        out_valid_next = out_valid_reg;
        lead_next      = lead_reg;
        fill_next      = fill_reg;
        count_next     = count_reg;
        last_next      = last_reg;

        case (state_reg)
            ST_CLEAR:
            begin
                clr_next = clr_reg + IDX_W'(1);
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    bits_next  = bits;
                    idx_next   = idx_in;
                    flush_next = (func_t'(func) == FUNC_FLUSH);
                    if (func_t'(func) == FUNC_FLUSH)
                    begin
                        cnt_next = FLUSH_STEPS;
                    end
                    else if (func_t'(func) == FUNC_BYPASS)
                    begin
                        cnt_next = byp_count;
                    end
                    else
                    begin
                        cnt_next = 4'd0;
                    end
                end
            end
            ST_MUPD:
            begin
                if (bits_reg[0])
                begin
                    range_next = model_part;
                end
                else
                begin
                    range_next = range_reg - model_part;
                    low_next   = low_reg + {1'b0, model_part};
                end
            end
            ST_BYPASS:
            begin
                range_next = range_half;
                if (byp_bit)
                begin
                    low_next = low_reg + {1'b0, range_half};
                end
                cnt_next = cnt_reg - 4'd1;
            end
            ST_RENORM:
            begin
                if (do_step)
                begin
                    range_next = range_reg << 8;
                end
                if (!need_renorm && (cnt_reg == 4'd0) && flush_reg)
                begin
                    cnt_next = FLUSH_STEPS;
                end
            end
            ST_FLUSH:
            begin
                if (do_step)
                begin
                    cnt_next = cnt_reg - 4'd1;
                end
            end
            default:
            begin
                cnt_next = cnt_reg;
            end
        endcase

        if (do_step)
        begin
            low_next = step_low;
            if (step_release)
            begin
                held_next      = low_reg[31:24];
                pend_next      = 32'd0;
                stg_valid_next = 1'b1;
                stg_lead_next  = step_lead;
                stg_fill_next  = step_fill;
                stg_count_next = pend_reg;
            end
            else
            begin
                pend_next = pend_reg + 32'd1;
            end
        end

        if (do_finish)
        begin
            stg_valid_next = 1'b0;
        end

        if (push_out)
        begin
            out_valid_next = 1'b1;
            lead_next      = stg_lead_reg;
            fill_next      = stg_fill_reg;
            count_next     = stg_count_reg;
            last_next      = do_finish;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            cnt_reg       <= 4'd0;
            flush_reg     <= 1'b0;
            clr_reg       <= '0;
            range_reg     <= 32'hFFFF_FFFF;
            low_reg       <= 33'd0;
            held_reg      <= 8'd0;
            pend_reg      <= 32'd0;
            stg_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            flush_reg     <= flush_next;
            clr_reg       <= clr_next;
            range_reg     <= range_next;
            low_reg       <= low_next;
            held_reg      <= held_next;
            pend_reg      <= pend_next;
            stg_valid_reg <= stg_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bits_reg      <= bits_next;
        idx_reg       <= idx_next;
        stg_lead_reg  <= stg_lead_next;
        stg_fill_reg  <= stg_fill_next;
        stg_count_reg <= stg_count_next;
        lead_reg      <= lead_next;
        fill_reg      <= fill_next;
        count_reg     <= count_next;
        last_reg      <= last_next;
    end

    assign out_valid  = out_valid_reg;
    assign lead_byte  = lead_reg;
    assign fill_byte  = fill_reg;
    assign fill_count = count_reg;
    assign last       = last_reg;

    `ABRE_ASSERT_IMP(a_idle_stage_empty, in_ready, !stg_valid_reg, "staged result left over between items")
    `ABRE_ASSERT_IMP(a_idle_range_norm, in_ready, range_reg[31:24] != 8'h00, "range not normalized between items")
    `ABRE_ASSERT_IMP(a_push_room, push_out, out_free, "result pushed into a busy output register")
    `ABRE_ASSERT(a_write_after_read, (state_reg != ST_MUPD) || ($past(state_reg) == ST_MCALC), "context write without a fresh read")

endmodule

`default_nettype wire
